>>> hw/rtl/qse_pkg.sv
`default_nettype none

package qse_pkg;

	// Store geometry
	localparam int IDX_W   = 10;
	localparam int DEPTH   = 1 << IDX_W;
	localparam int WORD_W  = 32;
	localparam int SP_W    = IDX_W + 1;
	localparam int STK_W   = 2 * IDX_W;
	localparam int CFG_W   = IDX_W;
	localparam int CFG_IDX_W = 1;

	// Item kinds
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_SORT  = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST = 1'b0,
		CFG_LAST  = 1'b1
	} cfg_reg_t;

	// Sort sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POP,
		ST_POP_WAIT,
		ST_LOAD,
		ST_PIVOT,
		ST_LSCAN,
		ST_RSCAN,
		ST_SWAP_L,
		ST_SWAP_R,
		ST_LNEXT,
		ST_FIN_LO,
		ST_FIN_Q,
		ST_PUSH_LO,
		ST_PUSH_HI,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/qse_ram.sv
`default_nettype none

// Simple dual-port RAM: one write, one registered read (read-first).
module qse_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/quicksort_engine_top.sv
`default_nettype none

// In-place quicksort engine over a 1024-entry store of signed 32-bit words.
// Write items (kind 0) store value at index and give no result; read items
// (kind 2) return the word at index with sort_done low; a sort item (kind 1)
// sorts entries first_index..last_index ascending and returns one beat with
// sort_done high and data zero; kind 3 is dropped. Writes and reads stream
// back to back while the output is not stalled. A sort walks the store through the
// single read port of the element RAM, one element per cycle during a scan.
// Pending ranges live in a second RAM used as a stack. first_index/last_index
// must only be written while idle.
module quicksort_engine_top
	import qse_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           kind,
	input  wire logic [IDX_W-1:0]     index,
	input  wire logic signed [WORD_W-1:0] value,
	// output channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [WORD_W-1:0]  data,
	output logic                      sort_done
);

	state_t state_q, state_d;

	logic [IDX_W-1:0]         first_index_q, last_index_q;
	logic [IDX_W-1:0]         lo_q, hi_q, l_q, r_q;
	logic [SP_W-1:0]          sp_q;
	logic signed [WORD_W-1:0] pivot_q, lval_q, rval_q;
	logic                     rfirst_q;
	logic                     rd_pend_s1;
	logic                     out_valid_q, sort_done_q;
	logic signed [WORD_W-1:0] data_q;

	// element RAM ports
	logic                     e_we, e_re;
	logic [IDX_W-1:0]         e_waddr, e_raddr;
	logic [WORD_W-1:0]        e_wdata, e_rdata;
	logic signed [WORD_W-1:0] e_rval;

	// range stack RAM ports
	logic                     s_we, s_re;
	logic [IDX_W-1:0]         s_waddr, s_raddr;
	logic [STK_W-1:0]         s_wdata, s_rdata;

	logic out_free, in_acc, acc_write, acc_sort, acc_read;
	logic lcont, rcont, push_lo_ok, push_hi_ok, sp_room;
	logic [SP_W-1:0] sp_after_lo;
	logic [IDX_W:0]  r_plus1;

	assign e_rval    = $signed(e_rdata);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && (!rd_pend_s1 || out_free));
	assign in_acc    = in_valid && !in_stall;
	assign acc_write = in_acc && (kind == KIND_WRITE);
	assign acc_sort  = in_acc && (kind == KIND_SORT);
	assign acc_read  = in_acc && (kind == KIND_READ);

	// scan continue conditions
	assign lcont = (e_rval <= pivot_q) && (l_q < hi_q);
	assign rcont = (e_rval > pivot_q) && (r_q > lo_q);

	// push decisions after the pivot lands at r_q
	assign sp_room     = sp_q < SP_W'(DEPTH);
	assign push_lo_ok  = (r_q > lo_q) && (lo_q < r_q - 1'b1) && sp_room;
	assign r_plus1     = {1'b0, r_q} + 1'b1;
	assign sp_after_lo = sp_q;
	assign push_hi_ok  = (r_plus1 < {1'b0, hi_q}) && (sp_q < SP_W'(DEPTH));

	qse_ram #(.DATA_W(WORD_W), .ADDR_W(IDX_W)) u_elem (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	qse_ram #(.DATA_W(STK_W), .ADDR_W(IDX_W)) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM control
	always_comb begin
		state_d = state_q;
		e_we    = 1'b0;
		e_waddr = l_q;
		e_wdata = rval_q;
		e_re    = 1'b0;
		e_raddr = l_q;
		s_we    = 1'b0;
		s_waddr = sp_q[IDX_W-1:0];
		s_wdata = {lo_q, r_q - 1'b1};
		s_re    = 1'b0;
		s_raddr = sp_q[IDX_W-1:0] - 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (acc_write) begin
					e_we    = 1'b1;
					e_waddr = index;
					e_wdata = value;
				end
				if (acc_read) begin
					e_re    = 1'b1;
					e_raddr = index;
				end
				if (acc_sort) begin
					state_d = (first_index_q < last_index_q) ? ST_LOAD : ST_DONE;
				end
			end
			ST_POP: begin
				s_re    = 1'b1;
				state_d = ST_POP_WAIT;
			end
			ST_POP_WAIT: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				e_re    = 1'b1;
				e_raddr = lo_q;
				state_d = ST_PIVOT;
			end
			ST_PIVOT: begin
				e_re    = 1'b1;
				e_raddr = lo_q + 1'b1;
				state_d = ST_LSCAN;
			end
			ST_LSCAN: begin
				e_re = 1'b1;
				if (lcont) begin
					e_raddr = l_q + 1'b1;
				end else begin
					e_raddr = rfirst_q ? hi_q : r_q - 1'b1;
					state_d = ST_RSCAN;
				end
			end
			ST_RSCAN: begin
				if (rcont) begin
					e_re    = 1'b1;
					e_raddr = r_q - 1'b1;
				end else begin
					state_d = (l_q < r_q) ? ST_SWAP_L : ST_FIN_LO;
				end
			end
			ST_SWAP_L: begin
				e_we    = 1'b1;
				e_waddr = l_q;
				e_wdata = rval_q;
				state_d = ST_SWAP_R;
			end
			ST_SWAP_R: begin
				e_we    = 1'b1;
				e_waddr = r_q;
				e_wdata = lval_q;
				state_d = ST_LNEXT;
			end
			ST_LNEXT: begin
				e_re    = 1'b1;
				e_raddr = l_q + 1'b1;
				state_d = ST_LSCAN;
			end
			ST_FIN_LO: begin
				e_we    = 1'b1;
				e_waddr = lo_q;
				e_wdata = rval_q;
				state_d = ST_FIN_Q;
			end
			ST_FIN_Q: begin
				e_we    = 1'b1;
				e_waddr = r_q;
				e_wdata = pivot_q;
				state_d = ST_PUSH_LO;
			end
			ST_PUSH_LO: begin
				s_we    = push_lo_ok;
				s_waddr = sp_after_lo[IDX_W-1:0];
				s_wdata = {lo_q, r_q - 1'b1};
				state_d = ST_PUSH_HI;
			end
			ST_PUSH_HI: begin
				s_we    = push_hi_ok;
				s_waddr = sp_q[IDX_W-1:0];
				s_wdata = {r_plus1[IDX_W-1:0], hi_q};
				if (push_hi_ok || (sp_q != '0)) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free && !rd_pend_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_index_q <= '0;
			last_index_q  <= IDX_W'(DEPTH - 1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST: first_index_q <= cfg_data;
				CFG_LAST:  last_index_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Stack pointer and sort flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			rfirst_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE:    if (acc_sort) sp_q <= '0;
				ST_POP:     sp_q <= sp_q - 1'b1;
				ST_PIVOT:   rfirst_q <= 1'b1;
				ST_RSCAN:   if (!rcont) rfirst_q <= 1'b0;
				ST_PUSH_LO: if (push_lo_ok) sp_q <= sp_q + 1'b1;
				ST_PUSH_HI: if (push_hi_ok) sp_q <= sp_q + 1'b1;
				default:    ;
			endcase
		end
	end

	// Partition datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc_sort) begin
					lo_q <= first_index_q;
					hi_q <= last_index_q;
				end
			end
			ST_POP_WAIT: begin
				lo_q <= s_rdata[STK_W-1:IDX_W];
				hi_q <= s_rdata[IDX_W-1:0];
			end
			ST_PIVOT: begin
				pivot_q <= e_rval;
				l_q     <= lo_q + 1'b1;
			end
			ST_LSCAN: begin
				if (lcont) begin
					l_q <= l_q + 1'b1;
				end else begin
					lval_q <= e_rval;
					r_q    <= rfirst_q ? hi_q : r_q - 1'b1;
				end
			end
			ST_RSCAN: begin
				if (rcont) begin
					r_q <= r_q - 1'b1;
				end else begin
					rval_q <= e_rval;
				end
			end
			ST_LNEXT: begin
				l_q <= l_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Read pending stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			sort_done_q <= 1'b0;
		end else begin
			if (acc_read) begin
				rd_pend_s1 <= 1'b1;
			end else if (out_free) begin
				rd_pend_s1 <= 1'b0;
			end
			if (rd_pend_s1 && out_free) begin
				out_valid_q <= 1'b1;
				sort_done_q <= 1'b0;
			end else if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
				sort_done_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (rd_pend_s1 && out_free) begin
			data_q <= e_rval;
		end else if ((state_q == ST_DONE) && out_free) begin
			data_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign sort_done = sort_done_q;

endmodule

`default_nettype wire

>>> hw/rtl/qse_checker.sv
`default_nettype none

// Port-level checks for the sort engine.
module qse_sva
	import qse_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [1:0]           kind,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [WORD_W-1:0]    data,
	input wire logic                 sort_done
);

	// A stalled beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped under stall");

	// A stalled beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(data) && $stable(sort_done))
		else $error("output payload changed under stall");

	// Completion beats carry zero data
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sort_done |-> data == '0)
		else $error("sort completion with nonzero data");

	// The engine is busy right after taking a sort
	a_sort_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == KIND_SORT) |=> in_stall)
		else $error("input taken during sort");

endmodule

bind quicksort_engine_top qse_sva u_qse_sva (.*);

`default_nettype wire

>>> sim/qse_checker.sv
// Watches both channels of the sort engine, keeps a shadow copy of the element
// store and the range registers, and checks every result beat in order.
module qse_checker
	import qse_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]            cfg_data,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic [1:0]                  kind,
	input  wire logic [IDX_W-1:0]            index,
	input  wire logic signed [WORD_W-1:0]    value,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic signed [WORD_W-1:0]    data,
	input  wire logic                        sort_done,
	output int                               fail_count,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		logic                     sort_done;
	} result_t;

	logic signed [WORD_W-1:0] shadow_store [DEPTH];
	logic [IDX_W-1:0]         range_first;
	logic [IDX_W-1:0]         range_last;
	result_t                  result_q [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// The ascending order of a range is unique, so the exact partition
	// sequence does not matter for the store contents after a sort.
	// 10-bit range registers can never point past the store.
	function automatic void sort_range();
		int lo, hi, i, j;
		logic signed [WORD_W-1:0] key;
		lo = range_first;
		hi = range_last;
		if (lo >= hi)
			return;
		for (i = lo + 1; i <= hi; i++) begin
			key = shadow_store[i];
			j = i - 1;
			while (j >= lo && shadow_store[j] > key) begin
				shadow_store[j + 1] = shadow_store[j];
				j--;
			end
			shadow_store[j + 1] = key;
		end
	endfunction

	// Apply one accepted input beat and queue the result it causes
	function automatic void apply_item(input logic [1:0] k, input logic [IDX_W-1:0] idx,
			input logic signed [WORD_W-1:0] val);
		result_t res;
		case (k)
			KIND_WRITE: shadow_store[idx] = val;
			KIND_SORT: begin
				sort_range();
				res.data = '0;
				res.sort_done = 1'b1;
				result_q.push_back(res);
			end
			KIND_READ: begin
				res.data = shadow_store[idx];
				res.sort_done = 1'b0;
				result_q.push_back(res);
			end
			default: ; // unused kind is dropped by the block
		endcase
	endfunction

	// Sample both channels and the config port at the rising edge
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			range_first = '0;
			range_last = '1;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FIRST)
					range_first = cfg_data;
				else
					range_last = cfg_data;
			end
			if (in_valid && !in_stall)
				apply_item(kind, index, value);
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with nothing expected: data %0d sort_done %0b",
						$time, data, sort_done);
				end else begin
					want = result_q.pop_front();
					if (data !== want.data) begin
						fail_count++;
						$display("%0t: data mismatch: expected %0d, got %0d",
							$time, want.data, data);
					end
					if (sort_done !== want.sort_done) begin
						fail_count++;
						$display("%0t: sort_done mismatch: expected %0b, got %0b",
							$time, want.sort_done, sort_done);
					end
				end
			end
			pending = result_q.size();
		end
	end

endmodule

>>> sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import qse_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 500;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1000000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               kind;
	logic [IDX_W-1:0]         index;
	logic signed [WORD_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [WORD_W-1:0] data;
	logic                     sort_done;
	int                       fail_count;
	int                       pending;

	// Stimulus bookkeeping
	bit  written [DEPTH];
	int  written_list [$];
	int  rand_items, n_writes, n_reads, n_sorts, n_dropped, n_settings, widest;
	int  cycle_count;
	bit  tx_quiet, rx_quiet, long_hold_req;

	quicksort_engine_top dut (.*);

	qse_checker checker_i (.*);

	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random stall before each beat, one long hold-off on request
	initial begin : rx_side
		int hold;
		bit hold_taken;
		out_stall = 1'b0;
		hold_taken = 1'b0;
		forever begin
			if (long_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold = LONG_HOLD_CYCLES;
			end else begin
				hold = rx_quiet ? 0 : $urandom_range(0, 12);
			end
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3, 4: return $urandom_range(0, 16) - 8; // small values give duplicates
			default: return $urandom();
		endcase
	endfunction

	// Offer one beat after a random gap and hold it until accepted
	task automatic send_beat(input logic [1:0] k, input int idx, input logic [WORD_W-1:0] val);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		index <= idx[IDX_W-1:0];
		value <= val;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_item(input int idx, input logic [WORD_W-1:0] val);
		send_beat(KIND_WRITE, idx, val);
		if (!written[idx]) begin
			written[idx] = 1'b1;
			written_list.push_back(idx);
		end
		n_writes++;
		rand_items++;
	endtask

	task automatic read_item(input int idx);
		send_beat(KIND_READ, idx, $urandom());
		n_reads++;
		rand_items++;
	endtask

	task automatic sort_item();
		send_beat(KIND_SORT, $urandom_range(0, DEPTH - 1), $urandom());
		n_sorts++;
		rand_items++;
	endtask

	// Stop offering and wait until every result is back and the block is quiet
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write both range registers; only called when drained
	task automatic set_window(input int lo, input int hi);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIRST;
		cfg_data <= lo[CFG_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_LAST;
		cfg_data <= hi[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
		if (hi - lo + 1 > widest)
			widest = hi - lo + 1;
	endtask

	// One random phase: new window, fill it, then a random mix over it
	task automatic run_phase(input int p);
		int len, lo, n, r, i;
		bit saved_quiet;
		if (p == 1) begin
			len = $urandom_range(2, 24);
			lo = 0;
		end else if (p == 2) begin
			len = $urandom_range(2, 24);
			lo = DEPTH - len;
		end else if (p == 3) begin
			len = 128;
			lo = $urandom_range(0, DEPTH - len);
		end else if (p == 5) begin
			len = 1; // single-entry range: sort moves nothing
			lo = $urandom_range(0, DEPTH - 1);
		end else begin
			len = $urandom_range(2, 32);
			lo = $urandom_range(0, DEPTH - len);
		end
		drain();
		set_window(lo, lo + len - 1);
		tx_quiet = (p % 3 == 0);
		rx_quiet = (p % 4 == 1);
		for (i = lo; i < lo + len; i++)
			write_item(i, rand_word());

		// Long receiver hold-off while reads keep streaming in
		if (p == 4) begin
			saved_quiet = tx_quiet;
			tx_quiet = 1'b1;
			long_hold_req = 1'b1;
			for (i = 0; i < 48; i++)
				read_item(written_list[$urandom_range(0, written_list.size() - 1)]);
			tx_quiet = saved_quiet;
		end

		for (n = 0; n < 25; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				write_item(lo + $urandom_range(0, len - 1), rand_word());
			end else if (r < 45) begin
				write_item($urandom_range(0, DEPTH - 1), rand_word());
			end else if (r < 75) begin
				read_item(written_list[$urandom_range(0, written_list.size() - 1)]);
			end else if (r < 92) begin
				sort_item();
				// often read the window back right after the sort
				if ($urandom_range(0, 1))
					for (i = lo; i < lo + len && i < lo + 12; i++)
						read_item(i);
			end else begin
				send_beat(KIND_UNUSED, $urandom_range(0, DEPTH - 1), $urandom());
				n_dropped++;
			end
			if (p == 6 && n == 12)
				drain();
		end
	endtask

	initial begin : stimulus
		int i, p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FIRST;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_WRITE;
		index = '0;
		value = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extreme words and indexes, duplicates, the dropped kind
		write_item(0, 32'h8000_0000);
		write_item(1023, 32'h7fff_ffff);
		write_item(1, 32'hffff_ffff);
		write_item(2, 32'h0000_0000);
		write_item(3, 32'h7fff_ffff);
		write_item(4, 32'h8000_0000);
		write_item(5, 32'h0000_0001);
		send_beat(KIND_UNUSED, 1023, 32'hffff_ffff);
		n_dropped++;
		read_item(0);
		read_item(1023);
		read_item(1);

		// Inverted range: nothing moves, completion still comes
		drain();
		set_window(1023, 0);
		sort_item();
		read_item(1023);

		// Single-entry range
		drain();
		set_window(3, 3);
		sort_item();

		// Small range with duplicates and both extremes
		drain();
		set_window(0, 5);
		sort_item();
		for (i = 0; i <= 5; i++)
			read_item(i);

		rand_items = 0;
		for (p = 1; p <= 6 || rand_items < RANDOM_ITEMS; p++)
			run_phase(p);

		drain();
		$display("covered %0d writes, %0d reads, %0d sorts and %0d dropped items",
			n_writes, n_reads, n_sorts, n_dropped);
		$display("over %0d range settings (widest %0d entries), %0d cycles",
			n_settings, widest, cycle_count);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
